### hdl/ptt_pkg.sv
// Package for the periodic timer table: field widths, command and result
// codes, the stored entry layout and the default table size.
// Depends on nothing.
package ptt_pkg;

   localparam int MAX_TIMERS_DEF = 16;

   localparam int CMD_W    = 2;
   localparam int TIME_W   = 48;
   localparam int OWNER_W  = 16;
   localparam int PERIOD_W = 31;
   localparam int KIND_W   = 3;
   localparam int TL_W     = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER = 2'd0,
      CMD_DISPATCH = 2'd1,
      CMD_QUERY    = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_REGISTERED = 3'd0,
      KIND_FULL       = 3'd1,
      KIND_FIRED      = 3'd2,
      KIND_NONE_DUE   = 3'd3,
      KIND_TIMEOUT    = 3'd4
   } kind_type;

   localparam logic signed [TL_W-1:0] TL_NONE = -32'sd1;
   localparam logic signed [TL_W-1:0] TL_MAX  = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [OWNER_W-1:0]  owner;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   due;
   } entry_type;

endpackage

### hdl/ptt_req_if.sv
// Request channel of the periodic timer table: valid/ready and the command
// payload. Depends on ptt_pkg.
interface ptt_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptt_pkg::CMD_W-1:0]     command;
   logic [ptt_pkg::TIME_W-1:0]    now;
   logic [ptt_pkg::OWNER_W-1:0]   owner_id;
   logic [ptt_pkg::PERIOD_W-1:0]  period;

   modport source (output valid, command, now, owner_id, period, input ready);
   modport sink   (input valid, command, now, owner_id, period, output ready);
endinterface

### hdl/ptt_rsp_if.sv
// Result channel of the periodic timer table: valid/ready and the result
// payload. Depends on ptt_pkg.
interface ptt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ptt_pkg::KIND_W-1:0]         kind;
   logic [ptt_pkg::OWNER_W-1:0]        fired_owner;
   logic signed [ptt_pkg::TL_W-1:0]    time_left;
   logic                               last;

   modport source (output valid, kind, fired_owner, time_left, last, input ready);
   modport sink   (input valid, kind, fired_owner, time_left, last, output ready);
endinterface

### hdl/periodic_timer_table_core.sv
// Periodic timer table core: entry memory, scan sequencer and result register.
// Depends on ptt_pkg, ptt_req_if and ptt_rsp_if.
//
// The block keeps up to MAX_TIMERS periodic timers in one synchronous memory
// (owner, period, due time per entry) and takes one request at a time. A
// register request gives one result. Dispatch and query walk the table
// through the memory's single read port, one entry per cycle, except that a
// full result register that is not taken holds a dispatch scan when another
// fired timer must be reported; dispatch writes each advanced due time back
// in the cycle it is examined and gives one result per fired timer, the final
// one flagged, or a single nothing-due result. Query gives one result with
// the time left to the earliest due time. Due times wrap at 48 bits.
module periodic_timer_table_core #(
   parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ptt_req_if.sink    req_ch,
   ptt_rsp_if.source  rsp_ch
);

   localparam int CW = $clog2(MAX_TIMERS + 1);
   localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TIMERS);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_REG    = 4'b0010,
      S_EVAL   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [IW-1:0]                 idx_ff, idx_in;
   ptt_pkg::cmd_type              cmd_ff, cmd_in;
   logic [ptt_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [ptt_pkg::OWNER_W-1:0]   owner_ff, owner_in;
   logic [ptt_pkg::PERIOD_W-1:0]  period_ff, period_in;
   logic [ptt_pkg::TIME_W-1:0]    min_ff, min_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [ptt_pkg::OWNER_W-1:0]   pend_owner_ff, pend_owner_in;

   logic                          out_valid_ff, out_valid_in;
   ptt_pkg::kind_type             out_kind_ff, out_kind_in;
   logic [ptt_pkg::OWNER_W-1:0]   out_owner_ff, out_owner_in;
   logic signed [ptt_pkg::TL_W-1:0] out_tl_ff, out_tl_in;
   logic                          out_last_ff, out_last_in;

   ptt_pkg::entry_type            mem [MAX_TIMERS];
   ptt_pkg::entry_type            rd_data_ff;
   ptt_pkg::entry_type            wr_data;
   logic                          rd_en, wr_en;
   logic [IW-1:0]                 rd_addr, wr_addr;

   logic                          accept, out_free, emit, at_end, fire;
   logic [CW-1:0]                 idx_next;
   logic [ptt_pkg::TIME_W-1:0]    diff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign idx_next = CW'(idx_ff) + CW'(1);
   assign at_end   = (idx_next == count_ff);
   assign fire     = (rd_data_ff.due <= now_ff);
   assign diff     = min_ff - now_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      owner_in      = owner_ff;
      period_in     = period_ff;
      min_in        = min_ff;
      pend_valid_in = pend_valid_ff;
      pend_owner_in = pend_owner_ff;
      emit          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_owner_in  = out_owner_ff;
      out_tl_in     = out_tl_ff;
      out_last_in   = out_last_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = ptt_pkg::cmd_type'(req_ch.command);
               now_in        = req_ch.now;
               owner_in      = req_ch.owner_id;
               period_in     = req_ch.period;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               rd_en         = 1'b1;
               rd_addr       = '0;
               case (ptt_pkg::cmd_type'(req_ch.command))
                  ptt_pkg::CMD_REGISTER: state_in = S_REG;
                  ptt_pkg::CMD_DISPATCH, ptt_pkg::CMD_QUERY: begin
                     state_in = (count_ff == '0) ? S_FINISH : S_EVAL;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_REG: begin
            if (out_free) begin
               emit         = 1'b1;
               out_owner_in = '0;
               out_tl_in    = '0;
               out_last_in  = 1'b1;
               if (count_ff == COUNT_MAX) begin
                  out_kind_in = ptt_pkg::KIND_FULL;
               end else begin
                  out_kind_in    = ptt_pkg::KIND_REGISTERED;
                  wr_en          = 1'b1;
                  wr_addr        = count_ff[IW-1:0];
                  wr_data.owner  = owner_ff;
                  wr_data.period = period_ff;
                  wr_data.due    = now_ff + ptt_pkg::TIME_W'(period_ff);
                  count_in       = count_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_EVAL: begin
            if (cmd_ff == ptt_pkg::CMD_QUERY) begin
               if (idx_ff == '0 || rd_data_ff.due < min_ff) begin
                  min_in = rd_data_ff.due;
               end
               if (at_end) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in  = idx_next[IW-1:0];
                  rd_en   = 1'b1;
                  rd_addr = idx_next[IW-1:0];
               end
            end else if (!(fire && pend_valid_ff && !out_free)) begin
               if (fire) begin
                  wr_en       = 1'b1;
                  wr_data.due = rd_data_ff.due + ptt_pkg::TIME_W'(rd_data_ff.period);
                  if (pend_valid_ff) begin
                     emit         = 1'b1;
                     out_kind_in  = ptt_pkg::KIND_FIRED;
                     out_owner_in = pend_owner_ff;
                     out_tl_in    = '0;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_owner_in = rd_data_ff.owner;
               end
               if (at_end) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in  = idx_next[IW-1:0];
                  rd_en   = 1'b1;
                  rd_addr = idx_next[IW-1:0];
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               emit         = 1'b1;
               out_last_in  = 1'b1;
               out_owner_in = '0;
               out_tl_in    = '0;
               if (cmd_ff == ptt_pkg::CMD_QUERY) begin
                  out_kind_in = ptt_pkg::KIND_TIMEOUT;
                  if (count_ff == '0) begin
                     out_tl_in = ptt_pkg::TL_NONE;
                  end else if (min_ff > now_ff) begin
                     if (diff[ptt_pkg::TIME_W-1:ptt_pkg::TL_W-1] != '0) begin
                        out_tl_in = ptt_pkg::TL_MAX;
                     end else begin
                        out_tl_in = ptt_pkg::TL_W'(diff[ptt_pkg::TL_W-2:0]);
                     end
                  end
               end else if (pend_valid_ff) begin
                  out_kind_in  = ptt_pkg::KIND_FIRED;
                  out_owner_in = pend_owner_ff;
               end else begin
                  out_kind_in = ptt_pkg::KIND_NONE_DUE;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      owner_ff      <= owner_in;
      period_ff     <= period_in;
      min_ff        <= min_in;
      pend_owner_ff <= pend_owner_in;
      out_kind_ff   <= out_kind_in;
      out_owner_ff  <= out_owner_in;
      out_tl_ff     <= out_tl_in;
      out_last_ff   <= out_last_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.kind        = out_kind_ff;
   assign rsp_ch.fired_owner = out_owner_ff;
   assign rsp_ch.time_left   = out_tl_ff;
   assign rsp_ch.last        = out_last_ff;

endmodule
